FILE: src/mctc_pkg.sv
// ----------------------------------------------------------------------------
// mctc_pkg
// Shared types, codes and constants of the MIME content-transfer classifier.
// ----------------------------------------------------------------------------
package mctc_pkg;

    localparam int unsigned LINE_COUNT_BITS_DEF = 10;
    localparam int unsigned LIMIT_W             = 10;
    localparam int unsigned ADDR_W              = 5;
    localparam int unsigned DATA_W              = 32;

    // register indexes
    localparam logic [2:0] REG_CONTENT_KIND   = 3'd0;
    localparam logic [2:0] REG_ALLOW_CTRL     = 3'd1;
    localparam logic [2:0] REG_TARGET_ENC     = 3'd2;
    localparam logic [2:0] REG_LINE_LIMIT     = 3'd3;
    localparam logic [2:0] REG_CHARSET_GIVEN  = 3'd4;

    // content kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TEXT = 2'd1;

    // transfer encodings
    localparam logic [1:0] ENC_7BIT   = 2'd0;
    localparam logic [1:0] ENC_8BIT   = 2'd1;
    localparam logic [1:0] ENC_QP     = 2'd2;
    localparam logic [1:0] ENC_BASE64 = 2'd3;

    // content-type actions
    localparam logic [1:0] TYPE_KEEP  = 2'd0;
    localparam logic [1:0] TYPE_OCTET = 2'd1;
    localparam logic [1:0] TYPE_PLAIN = 2'd2;

    // charset actions
    localparam logic [1:0] CS_KEEP    = 2'd0;
    localparam logic [1:0] CS_BINARY  = 2'd1;
    localparam logic [1:0] CS_ITERATE = 2'd2;
    localparam logic [1:0] CS_SEVEN   = 2'd3;

    // flag bit positions
    localparam int unsigned FL_HIGH   = 0;
    localparam int unsigned FL_LONG   = 1;
    localparam int unsigned FL_CTRL   = 2;
    localparam int unsigned FL_BIN    = 3;
    localparam int unsigned FL_NOTERM = 4;
    localparam int unsigned FL_FROM   = 5;

    // byte codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [2:0] PREFIX_LEN = 3'd5;

    localparam logic [1:0] TARGET_RESET = ENC_8BIT;
    localparam logic [9:0] LIMIT_RESET  = 10'd998;

    typedef struct packed {
        logic [1:0]         content_kind;
        logic               allow_text_controls;
        logic [1:0]         target_encoding;
        logic [LIMIT_W-1:0] line_limit;
        logic               charset_given;
    } t_cfg;

    typedef struct packed {
        logic [5:0] flags;
        logic [7:0] prev_byte;
        logic       stopped;
        logic       any_seen;
        logic       long_now;
    } t_scan_status;

    // "From " pattern
    function automatic logic [7:0] from_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h46;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h6F;
            3'd3:    ch = 8'h6D;
            3'd4:    ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: src/mctc_regs.sv
// ----------------------------------------------------------------------------
// mctc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module mctc_regs
    import mctc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_CONTENT_KIND:  n_cfg.content_kind        = pwdata[1:0];
                REG_ALLOW_CTRL:    n_cfg.allow_text_controls = pwdata[0];
                REG_TARGET_ENC:    n_cfg.target_encoding     = pwdata[1:0];
                REG_LINE_LIMIT:    n_cfg.line_limit          = pwdata[LIMIT_W-1:0];
                REG_CHARSET_GIVEN: n_cfg.charset_given       = pwdata[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CONTENT_KIND:  prdata = DATA_W'(r_cfg.content_kind);
            REG_ALLOW_CTRL:    prdata = DATA_W'(r_cfg.allow_text_controls);
            REG_TARGET_ENC:    prdata = DATA_W'(r_cfg.target_encoding);
            REG_LINE_LIMIT:    prdata = DATA_W'(r_cfg.line_limit);
            REG_CHARSET_GIVEN: prdata = DATA_W'(r_cfg.charset_given);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.content_kind        <= KIND_NONE;
            r_cfg.allow_text_controls <= 1'b0;
            r_cfg.target_encoding     <= TARGET_RESET;
            r_cfg.line_limit          <= LIMIT_RESET;
            r_cfg.charset_given       <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/mctc_scan.sv
// ----------------------------------------------------------------------------
// mctc_scan
// Per-byte scan state: sticky flags, line length, previous byte and prefix.
// ----------------------------------------------------------------------------
module mctc_scan
    import mctc_pkg::*;
#(
    parameter int unsigned LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  logic         i_clear,
    input  logic [7:0]   i_byte,
    input  t_cfg         i_cfg,
    output t_scan_status o_status
);

    localparam int unsigned CMP_W =
        (LINE_COUNT_BITS > LIMIT_W) ? LINE_COUNT_BITS : LIMIT_W;
    localparam logic [LINE_COUNT_BITS-1:0] LEN_MAX  = {LINE_COUNT_BITS{1'b1}};
    localparam logic [LINE_COUNT_BITS-1:0] LEN_FIVE = LINE_COUNT_BITS'(5);
    localparam logic [LINE_COUNT_BITS-1:0] LEN_FOUR = LINE_COUNT_BITS'(4);
    localparam logic [LINE_COUNT_BITS-1:0] LEN_ONE  = LINE_COUNT_BITS'(1);

    logic [5:0]                 r_flags,    n_flags;
    logic [LINE_COUNT_BITS-1:0] r_line_len, n_line_len;
    logic [7:0]                 r_prev,     n_prev;
    logic [2:0]                 r_pcount,   n_pcount;
    logic                       r_pmatch,   n_pmatch;
    logic                       r_stopped,  n_stopped;
    logic                       r_any,      n_any;

    logic is_text;
    logic none_or_text;
    logic txt_ok;
    logic long_now;
    logic stop;
    logic [7:0] c;

    assign c            = i_byte;
    assign is_text      = (i_cfg.content_kind == KIND_TEXT);
    assign none_or_text = (i_cfg.content_kind == KIND_NONE) || is_text;
    assign txt_ok       = is_text && i_cfg.allow_text_controls;
    assign long_now     = CMP_W'(r_line_len) >= CMP_W'(i_cfg.line_limit);

    always_comb begin
        n_flags    = r_flags;
        n_line_len = r_line_len;
        n_prev     = r_prev;
        n_pcount   = r_pcount;
        n_pmatch   = r_pmatch;
        n_stopped  = r_stopped;
        n_any      = r_any;
        stop       = 1'b0;
        if (i_clear) begin
            n_flags    = '0;
            n_line_len = '0;
            n_prev     = CH_NUL;
            n_pcount   = '0;
            n_pmatch   = 1'b1;
            n_stopped  = 1'b0;
            n_any      = 1'b0;
        end else if (i_step && !r_stopped) begin
            n_any = 1'b1;
            priority if (c == CH_NUL) begin
                n_flags[FL_BIN] = 1'b1;
                stop = !txt_ok;
            end else if (c == CH_LF) begin
                if (long_now) begin
                    n_flags[FL_LONG] = 1'b1;
                end
                n_line_len = '0;
                n_pcount   = '0;
                n_pmatch   = 1'b1;
            end else begin
                if (r_prev == CH_CR) begin
                    n_flags[FL_CTRL] = 1'b1;
                end
                priority if (c < CH_SPACE || c == CH_DEL) begin
                    if (c != CH_TAB && c != CH_CR) begin
                        n_flags[FL_CTRL] = 1'b1;
                    end
                    if (!((c >= CH_BEL && c <= CH_CR) || c == CH_ESC)) begin
                        n_flags[FL_BIN] = 1'b1;
                        stop = !txt_ok;
                    end
                end else if (c[7]) begin
                    n_flags[FL_HIGH] = 1'b1;
                    if (!none_or_text) begin
                        n_flags[FL_BIN] = 1'b1;
                        stop = 1'b1;
                    end
                end else begin
                    if (!r_flags[FL_FROM] && r_line_len < LEN_FIVE) begin
                        if (r_pcount < PREFIX_LEN) begin
                            if (from_char(r_pcount) != c) begin
                                n_pmatch = 1'b0;
                            end
                            n_pcount = r_pcount + 3'd1;
                        end
                        if (r_line_len == LEN_FOUR && n_pcount == PREFIX_LEN
                            && n_pmatch) begin
                            n_flags[FL_FROM] = 1'b1;
                        end
                    end
                end
            end
            if (stop) begin
                n_stopped = 1'b1;
            end else begin
                if (c != CH_LF && r_line_len != LEN_MAX) begin
                    n_line_len = r_line_len + LEN_ONE;
                end
                n_prev = c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags    <= '0;
            r_line_len <= '0;
            r_prev     <= CH_NUL;
            r_pcount   <= '0;
            r_pmatch   <= 1'b1;
            r_stopped  <= 1'b0;
            r_any      <= 1'b0;
        end else begin
            r_flags    <= n_flags;
            r_line_len <= n_line_len;
            r_prev     <= n_prev;
            r_pcount   <= n_pcount;
            r_pmatch   <= n_pmatch;
            r_stopped  <= n_stopped;
            r_any      <= n_any;
        end
    end

    assign o_status.flags     = r_flags;
    assign o_status.prev_byte = r_prev;
    assign o_status.stopped   = r_stopped;
    assign o_status.any_seen  = r_any;
    assign o_status.long_now  = long_now;

    // a stopped scan always follows a byte
    a_stop_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> r_any)
        else $error("scan stopped with no byte seen");

    // a verdict leaves the state cleared
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (r_flags == '0 && !r_any && r_line_len == '0 && r_pmatch))
        else $error("state not cleared after verdict");

    // prefix counter never passes the pattern length
    a_prefix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> (r_pcount <= PREFIX_LEN))
        else $error("prefix counter overran");

endmodule

FILE: src/mctc_verdict.sv
// ----------------------------------------------------------------------------
// mctc_verdict
// End-of-body decision logic and the result register.
// ----------------------------------------------------------------------------
module mctc_verdict
    import mctc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_load,
    input  t_scan_status i_status,
    input  t_cfg         i_cfg,
    output logic [1:0]   o_conversion,
    output logic [1:0]   o_type_action,
    output logic         o_convert_charset,
    output logic [1:0]   o_charset_action,
    output logic [5:0]   o_seen_flags
);

    logic [1:0] r_conv,  n_conv;
    logic [1:0] r_tact,  n_tact;
    logic       r_iconv, n_iconv;
    logic [1:0] r_cact,  n_cact;
    logic [5:0] r_fl,    n_fl;

    logic is_text;
    logic none_or_text;
    logic txt_ok;
    logic [1:0] cs_text;

    assign is_text      = (i_cfg.content_kind == KIND_TEXT);
    assign none_or_text = (i_cfg.content_kind == KIND_NONE) || is_text;
    assign txt_ok       = is_text && i_cfg.allow_text_controls;

    always_comb begin
        n_fl    = i_status.flags;
        n_conv  = ENC_7BIT;
        n_tact  = TYPE_KEEP;
        n_iconv = 1'b0;
        n_cact  = CS_KEEP;
        cs_text = CS_KEEP;
        if (!i_status.any_seen) begin
            n_fl   = '0;
            n_tact = (i_cfg.content_kind == KIND_NONE) ? TYPE_PLAIN : TYPE_KEEP;
            n_cact = i_cfg.charset_given ? CS_KEEP : CS_SEVEN;
        end else begin
            if (!i_status.stopped && i_status.long_now) begin
                n_fl[FL_LONG] = 1'b1;
            end
            if (i_status.prev_byte != CH_LF) begin
                n_fl[FL_NOTERM] = 1'b1;
            end
            cs_text = i_cfg.charset_given ? CS_KEEP :
                      (n_fl[FL_HIGH] ? CS_ITERATE : CS_SEVEN);
            if (n_fl[FL_BIN]) begin
                n_conv = ENC_BASE64;
                if (txt_ok) begin
                    n_cact = cs_text;
                end else begin
                    n_tact = none_or_text ? TYPE_OCTET : TYPE_KEEP;
                    n_cact = i_cfg.charset_given ? CS_KEEP : CS_BINARY;
                end
            end else begin
                priority if (n_fl[FL_LONG] || n_fl[FL_CTRL] || n_fl[FL_NOTERM]
                             || n_fl[FL_FROM]) begin
                    n_conv  = (i_cfg.target_encoding == ENC_BASE64) ? ENC_BASE64 : ENC_QP;
                    n_iconv = none_or_text && n_fl[FL_HIGH];
                end else if (n_fl[FL_HIGH]) begin
                    n_conv  = i_cfg.target_encoding;
                    n_iconv = none_or_text;
                end else begin
                    n_conv = ENC_7BIT;
                end
                n_tact = (i_cfg.content_kind == KIND_NONE) ? TYPE_PLAIN : TYPE_KEEP;
                n_cact = cs_text;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_conv  <= n_conv;
            r_tact  <= n_tact;
            r_iconv <= n_iconv;
            r_cact  <= n_cact;
            r_fl    <= n_fl;
        end
    end

    assign o_conversion      = r_conv;
    assign o_type_action     = r_tact;
    assign o_convert_charset = r_iconv;
    assign o_charset_action  = r_cact;
    assign o_seen_flags      = r_fl;

endmodule

FILE: src/mime_content_transfer_classifier_top.sv
// ----------------------------------------------------------------------------
// mime_content_transfer_classifier_top
// Scans a message body one byte per beat and gives the transfer verdict.
//
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_stall   i_data_byte, i_end_of_body
//  out       source     o_out_valid / i_out_stall o_conversion .. o_seen_flags
//  cfg       sink       psel / penable / pready   paddr, pwdata, prdata
//
//  one beat a cycle unless the input stalls; a beat passes an input register, then the scan state
//  an end beat moves from its input register to the result register once the output is free
//  sync active-low reset clears scan state, config and both valid bits
//  the input stalls only while an end beat waits behind a held result
// ----------------------------------------------------------------------------
module mime_content_transfer_classifier_top
    import mctc_pkg::*;
#(
    parameter int unsigned LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_body,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_conversion,
    output logic [1:0]        o_type_action,
    output logic              o_convert_charset,
    output logic [1:0]        o_charset_action,
    output logic [5:0]        o_seen_flags,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       r_out_valid, n_out_valid;

    logic         in_accept;
    logic         out_free;
    logic         advance;
    logic         load;
    t_cfg         cfg;
    t_scan_status status;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!r_in_end || out_free);
    assign load       = advance && r_in_end;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign n_in_valid  = in_accept ? 1'b1 : (advance ? 1'b0 : r_in_valid);
    assign n_out_valid = load ? 1'b1 : (!i_out_stall ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_end_of_body;
        end
    end

    assign o_out_valid = r_out_valid;

    mctc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mctc_scan #(
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance && !r_in_end),
        .i_clear  (load),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_status (status)
    );

    mctc_verdict u_verdict (
        .i_clk             (i_clk),
        .i_load            (load),
        .i_status          (status),
        .i_cfg             (cfg),
        .o_conversion      (o_conversion),
        .o_type_action     (o_type_action),
        .o_convert_charset (o_convert_charset),
        .o_charset_action  (o_charset_action),
        .o_seen_flags      (o_seen_flags)
    );

    // an end beat taken from the input register shows up as a result
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_out_valid)
        else $error("end beat produced no result");

    // only an end beat blocked by a held result stalls the input
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_end && r_out_valid && i_out_stall))
        else $error("input stalled without a held result");

endmodule

FILE: verif/tb_mime_content_transfer_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mime_content_transfer_classifier_top
// Streams message bodies through the classifier and checks every verdict.
//
// A scoreboard class keeps its own copy of the register settings and of the
// scan state. It works out the expected verdict for each end beat, and each
// verdict that leaves the block is checked field by field against the oldest
// one waiting. A short directed set comes first. Random bodies follow under
// twelve register settings and three patterns of idling on the two channels.
// ----------------------------------------------------------------------------
import mctc_pkg::*;

typedef logic [7:0] t_byte_q[$];

typedef struct packed {
    logic [1:0] conversion;
    logic [1:0] type_action;
    logic       convert_charset;
    logic [1:0] charset_action;
    logic [5:0] seen_flags;
} t_verdict;

class transfer_verdict_board;
    localparam logic [39:0] FROM_PREFIX = "From ";

    t_cfg                           cfg;
    logic [5:0]                     flags;
    logic [LINE_COUNT_BITS_DEF-1:0] line_len;
    logic [7:0]                     prev_byte;
    int unsigned                    prefix_seen;
    bit                             prefix_ok;
    bit                             halted;
    bit                             body_started;
    t_verdict                       verdicts_due[$];
    int unsigned                    mismatches;

    function new();
        cfg = '{content_kind: KIND_NONE, allow_text_controls: 1'b0,
                target_encoding: TARGET_RESET, line_limit: LIMIT_RESET,
                charset_given: 1'b0};
        mismatches = 0;
        reset_scan();
    endfunction

    function void reset_scan();
        flags        = '0;
        line_len     = '0;
        prev_byte    = '0;
        prefix_seen  = 0;
        prefix_ok    = 1'b1;
        halted       = 1'b0;
        body_started = 1'b0;
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_CONTENT_KIND:  cfg.content_kind        = val[1:0];
            REG_ALLOW_CTRL:    cfg.allow_text_controls = val[0];
            REG_TARGET_ENC:    cfg.target_encoding     = val[1:0];
            REG_LINE_LIMIT:    cfg.line_limit          = val[LIMIT_W-1:0];
            REG_CHARSET_GIVEN: cfg.charset_given       = val[0];
            default: ;
        endcase
    endfunction

    // returns 1 when the byte halts the scan
    function bit absorb_byte(input logic [7:0] c);
        bit is_text;
        bit open_kind;
        bit ctrl_ok;
        is_text   = (cfg.content_kind == KIND_TEXT);
        open_kind = (cfg.content_kind == KIND_NONE) || is_text;
        ctrl_ok   = is_text && cfg.allow_text_controls;
        if (c == CH_NUL) begin
            flags[FL_BIN] = 1'b1;
            return !ctrl_ok;
        end
        if (c == CH_LF) begin
            if (line_len >= cfg.line_limit)
                flags[FL_LONG] = 1'b1;
            line_len    = '0;
            prefix_seen = 0;
            prefix_ok   = 1'b1;
            return 1'b0;
        end
        if (prev_byte == CH_CR)
            flags[FL_CTRL] = 1'b1;
        if (c < CH_SPACE || c == CH_DEL) begin
            if (c != CH_TAB && c != CH_CR)
                flags[FL_CTRL] = 1'b1;
            if (!((c >= CH_BEL && c <= CH_CR) || c == CH_ESC)) begin
                flags[FL_BIN] = 1'b1;
                if (!ctrl_ok)
                    return 1'b1;
            end
        end else if (c[7]) begin
            flags[FL_HIGH] = 1'b1;
            if (!open_kind) begin
                flags[FL_BIN] = 1'b1;
                return 1'b1;
            end
        end else if (!flags[FL_FROM] && line_len < 5) begin
            if (prefix_seen < 5) begin
                if (FROM_PREFIX[39 - 8*prefix_seen -: 8] != c)
                    prefix_ok = 1'b0;
                prefix_seen++;
            end
            if (line_len == 4 && prefix_seen == 5 && prefix_ok)
                flags[FL_FROM] = 1'b1;
        end
        return 1'b0;
    endfunction

    function t_verdict judge_body();
        t_verdict v;
        logic [5:0] fl;
        bit is_text;
        bit open_kind;
        bit ctrl_ok;
        is_text   = (cfg.content_kind == KIND_TEXT);
        open_kind = (cfg.content_kind == KIND_NONE) || is_text;
        ctrl_ok   = is_text && cfg.allow_text_controls;
        v = '0;
        if (!body_started) begin
            v.conversion     = ENC_7BIT;
            v.type_action    = (cfg.content_kind == KIND_NONE) ? TYPE_PLAIN : TYPE_KEEP;
            v.charset_action = cfg.charset_given ? CS_KEEP : CS_SEVEN;
            return v;
        end
        fl = flags;
        if (!halted && line_len >= cfg.line_limit)
            fl[FL_LONG] = 1'b1;
        if (prev_byte != CH_LF)
            fl[FL_NOTERM] = 1'b1;
        if (fl[FL_BIN]) begin
            v.conversion = ENC_BASE64;
            if (ctrl_ok) begin
                v.charset_action = cfg.charset_given ? CS_KEEP :
                                   (fl[FL_HIGH] ? CS_ITERATE : CS_SEVEN);
            end else begin
                v.type_action    = open_kind ? TYPE_OCTET : TYPE_KEEP;
                v.charset_action = cfg.charset_given ? CS_KEEP : CS_BINARY;
            end
        end else begin
            if (fl[FL_LONG] || fl[FL_CTRL] || fl[FL_NOTERM] || fl[FL_FROM]) begin
                v.conversion = (cfg.target_encoding == ENC_BASE64) ? ENC_BASE64 : ENC_QP;
                if (open_kind)
                    v.convert_charset = fl[FL_HIGH];
            end else if (fl[FL_HIGH]) begin
                v.conversion = cfg.target_encoding;
                if (open_kind)
                    v.convert_charset = 1'b1;
            end else begin
                v.conversion = ENC_7BIT;
            end
            v.type_action    = (cfg.content_kind == KIND_NONE) ? TYPE_PLAIN : TYPE_KEEP;
            v.charset_action = cfg.charset_given ? CS_KEEP :
                               (fl[FL_HIGH] ? CS_ITERATE : CS_SEVEN);
        end
        v.seen_flags = fl;
        return v;
    endfunction

    // returns 1 when the beat is not one the block ignores
    function bit note_beat(input logic [7:0] c, input logic eob);
        if (eob) begin
            verdicts_due.push_back(judge_body());
            reset_scan();
            return 1'b1;
        end
        if (halted)
            return 1'b0;
        body_started = 1'b1;
        if (absorb_byte(c)) begin
            halted = 1'b1;
        end else begin
            if (c != CH_LF && line_len != '1)
                line_len++;
            prev_byte = c;
        end
        return 1'b1;
    endfunction

    function void compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    function void check_verdict(input t_verdict got);
        t_verdict want;
        if (verdicts_due.size() == 0) begin
            $display("%0t: verdict expected none got %h", $time, got);
            mismatches++;
            return;
        end
        want = verdicts_due.pop_front();
        compare_field("conversion", want.conversion, got.conversion);
        compare_field("type_action", want.type_action, got.type_action);
        compare_field("convert_charset", want.convert_charset, got.convert_charset);
        compare_field("charset_action", want.charset_action, got.charset_action);
        compare_field("seen_flags", want.seen_flags, got.seen_flags);
    endfunction
endclass

module tb_mime_content_transfer_classifier_top;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned PHASE_BEATS   = 88;
    localparam int unsigned PHASES        = 12;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [7:0]        i_data_byte;
    logic              i_end_of_body;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [1:0]        o_conversion;
    logic [1:0]        o_type_action;
    logic              o_convert_charset;
    logic [1:0]        o_charset_action;
    logic [5:0]        o_seen_flags;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    transfer_verdict_board sb;
    int unsigned           tx_idle_pct = 0;
    int unsigned           rx_idle_pct = 0;
    int unsigned           beats_scanned = 0;
    int unsigned           cycle_count = 0;

    mime_content_transfer_classifier_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_end_of_body     (i_end_of_body),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_conversion      (o_conversion),
        .o_type_action     (o_type_action),
        .o_convert_charset (o_convert_charset),
        .o_charset_action  (o_charset_action),
        .o_seen_flags      (o_seen_flags),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_verdict('{o_conversion, o_type_action, o_convert_charset,
                               o_charset_action, o_seen_flags});
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_beat(input logic [7:0] b, input logic eob);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_data_byte   = b;
        i_end_of_body = eob;
        do @(posedge i_clk); while (o_in_stall);
        if (sb.note_beat(b, eob))
            beats_scanned++;
    endtask

    task automatic send_body(input t_byte_q q);
        foreach (q[i])
            send_beat(q[i], 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // hold the sender until every verdict is out and the block is quiet
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0]  mild_ctrl[7] = '{CH_BEL, CH_TAB, CH_CR, CH_ESC, 8'h08, 8'h0B, 8'h0C};
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 8'($urandom_range(8'h20, 8'h7E));
        if (r < 88)
            return 8'($urandom_range(8'h80, 8'hFF));
        if (r < 94)
            return mild_ctrl[$urandom_range(0, 6)];
        if (r < 97)
            return $urandom_range(0, 1) ? CH_DEL : 8'($urandom_range(1, 8'h1F));
        return CH_NUL;
    endfunction

    function automatic void build_body(output t_byte_q q, input int unsigned limit);
        int unsigned shape;
        int unsigned len;
        int unsigned max_len;
        string       lead;
        q = {};
        shape = $urandom_range(0, 99);
        if (shape < 8)
            return;
        if (shape < 22) begin
            repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        max_len = (limit < 100) ? limit + 2 : 30;
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 7))
                0, 1:    lead = "From ";
                2:       lead = "From";
                3:       lead = "Frum ";
                4:       lead = " From ";
                5:       lead = "from ";
                default: lead = "";
            endcase
            foreach (lead[i])
                q.push_back(lead[i]);
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 10) : $urandom_range(0, max_len);
            repeat (len) q.push_back(text_byte());
            if ($urandom_range(0, 3) == 0)
                q.push_back(CH_CR);
            q.push_back(CH_LF);
        end
        if ($urandom_range(0, 4) == 0)
            void'(q.pop_back());
    endfunction

    initial begin
        t_byte_q     body;
        int unsigned limit;
        int unsigned start;
        sb            = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_end_of_body = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_idle_pct   = 34;
        rx_idle_pct   = 81;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed bodies at reset settings
        body = {};
        send_body(body);
        body = '{"F", "r", "o", "m", " ", "x", CH_LF};
        send_body(body);
        body = '{8'hFF, CH_CR, CH_LF};
        send_body(body);
        body = '{CH_NUL, "a"};
        send_body(body);
        body = '{"a", CH_CR, "b"};
        send_body(body);
        body = '{CH_ESC, CH_BEL, CH_TAB, CH_DEL};
        send_body(body);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            tx_idle_pct = (p < 4) ? 34 : (p < 8) ? 81 : 0;
            rx_idle_pct = (p < 4) ? 81 : (p < 8) ? 34 : 0;
            limit = (p == 1) ? 1 : (p == 6) ? 1023 : $urandom_range(2, 40);
            write_reg(REG_CONTENT_KIND, p % 4);
            write_reg(REG_ALLOW_CTRL, (p / 4 + p) % 2);
            write_reg(REG_TARGET_ENC, p / 3);
            write_reg(REG_LINE_LIMIT, limit);
            write_reg(REG_CHARSET_GIVEN, (p / 2) % 2);
            start = beats_scanned;
            while (beats_scanned - start < PHASE_BEATS) begin
                build_body(body, limit);
                send_body(body);
            end
            settle();
        end

        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
